// ===== rtl/ipk_pkg.sv =====
// ipk_pkg: shared constants and types for the iambic paddle keyer.
// Used by the result channel interface, the debounce ring and the keyer top level.
package ipk_pkg;

  // Debounce ring
  localparam int FILTER_LEN = 16;
  localparam int PTR_W      = (FILTER_LEN > 1) ? $clog2(FILTER_LEN) : 1;
  localparam int SUM_W      = $clog2(FILTER_LEN + 1);
  localparam int THR_W      = 5;
  localparam int CMP_W      = (SUM_W > THR_W) ? SUM_W : THR_W;

  // Letter collection
  localparam int MAX_ELEMENTS = 8;
  localparam int LEN_W        = 4;
  localparam int PAT_W        = 8;
  localparam int BIT_IDX_W    = $clog2(PAT_W);

  // Timers
  localparam int TICK_W    = 16;
  localparam int SILENCE_W = TICK_W + 1;
  localparam logic [SILENCE_W-1:0] SILENCE_AT_RESET = SILENCE_W'(100);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEYER_ENABLE      = 3'd0,
    REG_PRESS_THRESHOLD   = 3'd1,
    REG_DIT_TICKS         = 3'd2,
    REG_DAH_TICKS         = 3'd3,
    REG_ELEMENT_GAP_TICKS = 3'd4,
    REG_LETTER_GAP_TICKS  = 3'd5,
    REG_WORD_GAP_TICKS    = 3'd6
  } cfg_reg_t;

  // Debounced paddle states
  typedef struct packed {
    logic dah;
    logic dit;
  } pressed_t;

  // One raw sample of both paddles, as stored in the ring
  typedef struct packed {
    logic dah;
    logic dit;
  } sample_t;

endpackage

// ===== rtl/ipk_paddle_if.sv =====
// ipk_paddle_if: input channel, one beat per tick with raw paddle levels.
// Depends on nothing but valid/ready handshake conventions.
interface ipk_paddle_if;
  logic valid;
  logic ready;
  logic raw_dit;
  logic raw_dah;

  modport source (output valid, output raw_dit, output raw_dah, input ready);
  modport sink   (input valid, input raw_dit, input raw_dah, output ready);
endinterface

// ===== rtl/ipk_report_if.sv =====
// ipk_report_if: result channel, one beat per tick with keyer events.
// Field widths come from ipk_pkg.
interface ipk_report_if;
  logic                     valid;
  logic                     ready;
  logic                     dit_pressed;
  logic                     dah_pressed;
  logic                     tone_on;
  logic                     element_start;
  logic                     element_is_dah;
  logic                     letter_done;
  logic [ipk_pkg::LEN_W-1:0] letter_length;
  logic [ipk_pkg::PAT_W-1:0] letter_pattern;
  logic                     word_space;

  modport source (
    output valid, output dit_pressed, output dah_pressed, output tone_on,
    output element_start, output element_is_dah, output letter_done,
    output letter_length, output letter_pattern, output word_space,
    input ready
  );
  modport sink (
    input valid, input dit_pressed, input dah_pressed, input tone_on,
    input element_start, input element_is_dah, input letter_done,
    input letter_length, input letter_pattern, input word_space,
    output ready
  );
endinterface

// ===== rtl/ipk_debounce.sv =====
// ipk_debounce: moving-sum debouncer for both paddles over a sample ring.
// The ring is a synchronous RAM read one tick ahead; uses ipk_pkg.
module ipk_debounce (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  ipk_pkg::sample_t           sample,
  input  logic [ipk_pkg::THR_W-1:0]  threshold,
  output ipk_pkg::pressed_t          pressed
);

  ipk_pkg::sample_t                 ring [ipk_pkg::FILTER_LEN];
  logic [ipk_pkg::FILTER_LEN-1:0]   filled;
  logic [ipk_pkg::PTR_W-1:0]        pos;
  logic [ipk_pkg::PTR_W-1:0]        pos_inc;
  logic [ipk_pkg::PTR_W-1:0]        rd_addr;
  ipk_pkg::sample_t                 rd_data;
  logic                             rd_vld;
  ipk_pkg::sample_t                 oldest;
  logic [ipk_pkg::SUM_W-1:0]        dit_sum, dah_sum;
  logic [ipk_pkg::SUM_W-1:0]        dit_sum_next, dah_sum_next;

  // Ring pointer wraps at the filter length
  assign pos_inc = (pos == ipk_pkg::PTR_W'(ipk_pkg::FILTER_LEN - 1))
                   ? '0 : pos + 1'b1;
  // Prefetch the slot the next beat will retire
  assign rd_addr = accept ? pos_inc : pos;

  // Slots never written since reset read as zero
  assign oldest = rd_vld ? rd_data : '0;

  assign dit_sum_next = dit_sum - ipk_pkg::SUM_W'(oldest.dit)
                                + ipk_pkg::SUM_W'(sample.dit);
  assign dah_sum_next = dah_sum - ipk_pkg::SUM_W'(oldest.dah)
                                + ipk_pkg::SUM_W'(sample.dah);

  assign pressed.dit = ipk_pkg::CMP_W'(dit_sum_next) < ipk_pkg::CMP_W'(threshold);
  assign pressed.dah = ipk_pkg::CMP_W'(dah_sum_next) < ipk_pkg::CMP_W'(threshold);

  // Sample RAM: one write, one registered read
  always_ff @(posedge clk) begin
    if (accept) begin
      ring[pos] <= sample;
    end
    rd_data <= ring[rd_addr];
  end

  // Control: pointer, sums, per-slot fill flags
  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      dit_sum <= '0;
      dah_sum <= '0;
      filled  <= '0;
      rd_vld  <= 1'b0;
    end else begin
      rd_vld <= filled[rd_addr];
      if (accept) begin
        pos          <= pos_inc;
        dit_sum      <= dit_sum_next;
        dah_sum      <= dah_sum_next;
        filled[pos]  <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/iambic_paddle_keyer.sv =====
// iambic_paddle_keyer: iambic keyer with ring debounce and letter collection.
// A result beat is presented in the cycle after its tick is accepted.
// Throughput: one tick per cycle unless the result sink stalls; the ring RAM is prefetched a tick ahead.
// A tick is taken whenever the result register is empty or being drained.
// Reset (rst, synchronous) restores register defaults, empties the ring
// (unwritten slots read as zero) and loads the silence timer with 100.
module iambic_paddle_keyer (
  input  logic                           clk,
  input  logic                           rst,
  ipk_paddle_if.sink                     paddle,
  ipk_report_if.source                   report,
  input  logic                           cfg_we,
  input  logic [ipk_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ipk_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  logic                        keyer_enable;
  logic [ipk_pkg::THR_W-1:0]   press_threshold;
  logic [ipk_pkg::TICK_W-1:0]  dit_ticks, dah_ticks;
  logic [ipk_pkg::TICK_W-1:0]  element_gap_ticks, letter_gap_ticks, word_gap_ticks;

  // Keyer state
  logic                           next_is_dah, next_is_dah_next;
  logic [ipk_pkg::TICK_W-1:0]     tone_remaining, tone_remaining_next;
  logic [ipk_pkg::SILENCE_W-1:0]  silence_remaining, silence_remaining_next;
  logic [ipk_pkg::TICK_W-1:0]     letter_gap_remaining, letter_gap_remaining_next;
  logic [ipk_pkg::TICK_W-1:0]     word_gap_remaining, word_gap_remaining_next;
  logic                           word_space_sent, word_space_sent_next;
  logic                           tone_state, tone_state_next;
  logic [ipk_pkg::LEN_W-1:0]      code_count, code_count_next;
  logic [ipk_pkg::PAT_W-1:0]      code_bits, code_bits_next;

  // Per-tick events
  logic                        ev_start, ev_is_dah, ev_letter, ev_word;
  logic [ipk_pkg::LEN_W-1:0]   ev_length;
  logic [ipk_pkg::PAT_W-1:0]   ev_pattern;

  logic               accept;
  ipk_pkg::sample_t   sample;
  ipk_pkg::pressed_t  pressed;
  logic               out_valid;

  assign paddle.ready = !out_valid || report.ready;
  assign accept       = paddle.valid && paddle.ready;
  assign sample.dit   = paddle.raw_dit;
  assign sample.dah   = paddle.raw_dah;

  ipk_debounce u_debounce (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .sample    (sample),
    .threshold (press_threshold),
    .pressed   (pressed)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      keyer_enable      <= 1'b1;
      press_threshold   <= ipk_pkg::THR_W'(8);
      dit_ticks         <= ipk_pkg::TICK_W'(60);
      dah_ticks         <= ipk_pkg::TICK_W'(180);
      element_gap_ticks <= ipk_pkg::TICK_W'(60);
      letter_gap_ticks  <= ipk_pkg::TICK_W'(120);
      word_gap_ticks    <= ipk_pkg::TICK_W'(240);
    end else if (cfg_we) begin
      unique case (cfg_index)
        ipk_pkg::REG_KEYER_ENABLE:      keyer_enable      <= cfg_data[0];
        ipk_pkg::REG_PRESS_THRESHOLD:   press_threshold   <= cfg_data[ipk_pkg::THR_W-1:0];
        ipk_pkg::REG_DIT_TICKS:         dit_ticks         <= cfg_data[ipk_pkg::TICK_W-1:0];
        ipk_pkg::REG_DAH_TICKS:         dah_ticks         <= cfg_data[ipk_pkg::TICK_W-1:0];
        ipk_pkg::REG_ELEMENT_GAP_TICKS: element_gap_ticks <= cfg_data[ipk_pkg::TICK_W-1:0];
        ipk_pkg::REG_LETTER_GAP_TICKS:  letter_gap_ticks  <= cfg_data[ipk_pkg::TICK_W-1:0];
        ipk_pkg::REG_WORD_GAP_TICKS:    word_gap_ticks    <= cfg_data[ipk_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Keyer next state for one tick
  always_comb begin
    logic start;
    logic is_dah;
    start  = 1'b0;
    is_dah = 1'b0;

    next_is_dah_next          = next_is_dah;
    tone_remaining_next       = tone_remaining;
    silence_remaining_next    = silence_remaining;
    letter_gap_remaining_next = letter_gap_remaining;
    word_gap_remaining_next   = word_gap_remaining;
    word_space_sent_next      = word_space_sent;
    tone_state_next           = tone_state;
    code_count_next           = code_count;
    code_bits_next            = code_bits;
    ev_start   = 1'b0;
    ev_is_dah  = 1'b0;
    ev_letter  = 1'b0;
    ev_length  = '0;
    ev_pattern = '0;
    ev_word    = 1'b0;

    if (keyer_enable) begin
      // Idle: drop an overflowed code, then pick the next element
      if (silence_remaining == '0) begin
        if (code_count >= ipk_pkg::LEN_W'(ipk_pkg::MAX_ELEMENTS)) begin
          code_count_next = '0;
          code_bits_next  = '0;
        end
        if (pressed.dit && pressed.dah) begin
          start            = 1'b1;
          is_dah           = next_is_dah;
          next_is_dah_next = !next_is_dah;
        end else if (pressed.dit) begin
          start            = 1'b1;
          is_dah           = 1'b0;
          next_is_dah_next = 1'b1;
        end else if (pressed.dah) begin
          start            = 1'b1;
          is_dah           = 1'b1;
          next_is_dah_next = 1'b0;
        end
        if (start) begin
          tone_remaining_next = is_dah ? dah_ticks : dit_ticks;
          if (code_count_next < ipk_pkg::LEN_W'(ipk_pkg::MAX_ELEMENTS)) begin
            if (is_dah) begin
              code_bits_next[code_count_next[ipk_pkg::BIT_IDX_W-1:0]] = 1'b1;
            end
            code_count_next = code_count_next + 1'b1;
          end
          letter_gap_remaining_next = letter_gap_ticks;
          silence_remaining_next    = ipk_pkg::SILENCE_W'(element_gap_ticks)
                                    + ipk_pkg::SILENCE_W'(tone_remaining_next);
          ev_start  = 1'b1;
          ev_is_dah = is_dah;
        end
      end

      // Timers, on the values after a possible start
      if (silence_remaining_next != '0) begin
        silence_remaining_next = silence_remaining_next - 1'b1;
        if (tone_remaining_next != '0) begin
          tone_state_next     = 1'b1;
          tone_remaining_next = tone_remaining_next - 1'b1;
        end else begin
          tone_state_next = 1'b0;
        end
      end else if (letter_gap_remaining_next != '0) begin
        letter_gap_remaining_next = letter_gap_remaining_next - 1'b1;
      end else if (code_count_next != '0) begin
        ev_letter               = 1'b1;
        ev_length               = code_count_next;
        ev_pattern              = code_bits_next;
        code_count_next         = '0;
        code_bits_next          = '0;
        word_gap_remaining_next = word_gap_ticks;
        word_space_sent_next    = 1'b0;
      end else if (word_gap_remaining_next != '0) begin
        word_gap_remaining_next = word_gap_remaining_next - 1'b1;
      end else if (!word_space_sent_next) begin
        ev_word              = 1'b1;
        word_space_sent_next = 1'b1;
      end
    end
  end

  // Keyer state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      next_is_dah          <= 1'b0;
      tone_remaining       <= '0;
      silence_remaining    <= ipk_pkg::SILENCE_AT_RESET;
      letter_gap_remaining <= '0;
      word_gap_remaining   <= '0;
      word_space_sent      <= 1'b0;
      tone_state           <= 1'b0;
      code_count           <= '0;
      code_bits            <= '0;
    end else if (accept) begin
      next_is_dah          <= next_is_dah_next;
      tone_remaining       <= tone_remaining_next;
      silence_remaining    <= silence_remaining_next;
      letter_gap_remaining <= letter_gap_remaining_next;
      word_gap_remaining   <= word_gap_remaining_next;
      word_space_sent      <= word_space_sent_next;
      tone_state           <= tone_state_next;
      code_count           <= code_count_next;
      code_bits            <= code_bits_next;
    end
  end

  // Result register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (report.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register: payload
  always_ff @(posedge clk) begin
    if (accept) begin
      report.dit_pressed    <= pressed.dit;
      report.dah_pressed    <= pressed.dah;
      report.tone_on        <= tone_state_next;
      report.element_start  <= ev_start;
      report.element_is_dah <= ev_is_dah;
      report.letter_done    <= ev_letter;
      report.letter_length  <= ev_length;
      report.letter_pattern <= ev_pattern;
      report.word_space     <= ev_word;
    end
  end

  assign report.valid = out_valid;

endmodule

// ===== test/tb.sv =====
// tb: self-checking bench for iambic_paddle_keyer, driving raw paddle ticks with
// bursty valid and a stalling result sink. A scoreboard class predicts each report.
// Depends on ipk_pkg, ipk_paddle_if, ipk_report_if and the keyer top level.
module tb;

  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 11;
  localparam int LONG_HOLD = 200;
  localparam int DRAIN_LIMIT = 5000;
  localparam int TIMEOUT_CYCLES = 200000;
  localparam logic [ipk_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  typedef enum int {RX_OPEN, RX_MOSTLY, RX_PERIODIC, RX_SPARSE} rx_mode_t;

  typedef struct packed {
    logic                      dit_pressed;
    logic                      dah_pressed;
    logic                      tone_on;
    logic                      element_start;
    logic                      element_is_dah;
    logic                      letter_done;
    logic [ipk_pkg::LEN_W-1:0] letter_length;
    logic [ipk_pkg::PAT_W-1:0] letter_pattern;
    logic                      word_space;
  } report_t;

  // Keyer shadow: debounce ring, element timers and letter collection
  class keyer_score;
    bit                          keyer_on;
    bit [ipk_pkg::THR_W-1:0]     press_limit;
    bit [ipk_pkg::TICK_W-1:0]    dit_len, dah_len, elem_gap, letter_gap, word_gap;
    bit                          dit_ring[ipk_pkg::FILTER_LEN];
    bit                          dah_ring[ipk_pkg::FILTER_LEN];
    bit [ipk_pkg::SUM_W-1:0]     dit_total, dah_total;
    bit [ipk_pkg::PTR_W-1:0]     ring_ptr;
    bit                          dah_next, space_done, tone_level;
    bit [ipk_pkg::TICK_W-1:0]    tone_left, letter_left, word_left;
    bit [ipk_pkg::SILENCE_W-1:0] quiet_left;
    bit [ipk_pkg::LEN_W-1:0]     elem_count;
    bit [ipk_pkg::PAT_W-1:0]     elem_bits;
    report_t                     due_reports[$];
    int                          fault_count;

    function new();
      keyer_on = 1'b1;
      press_limit = 5'd8;
      dit_len = 16'd60;
      dah_len = 16'd180;
      elem_gap = 16'd60;
      letter_gap = 16'd120;
      word_gap = 16'd240;
      quiet_left = ipk_pkg::SILENCE_AT_RESET;
      fault_count = 0;
    endfunction

    function void write_reg(logic [ipk_pkg::CFG_IDX_W-1:0] idx,
                            logic [ipk_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        ipk_pkg::REG_KEYER_ENABLE:      keyer_on = value[0];
        ipk_pkg::REG_PRESS_THRESHOLD:   press_limit = value[ipk_pkg::THR_W-1:0];
        ipk_pkg::REG_DIT_TICKS:         dit_len = value;
        ipk_pkg::REG_DAH_TICKS:         dah_len = value;
        ipk_pkg::REG_ELEMENT_GAP_TICKS: elem_gap = value;
        ipk_pkg::REG_LETTER_GAP_TICKS:  letter_gap = value;
        ipk_pkg::REG_WORD_GAP_TICKS:    word_gap = value;
        default: ;
      endcase
    endfunction

    // One accepted tick: update the shadow and queue the report it yields
    function void note_tick(bit rd, bit rh);
      report_t r;
      bit dp, hp, go, kind;
      r = '0;
      go = 1'b0;
      kind = 1'b0;
      dit_total = dit_total - dit_ring[ring_ptr] + rd;
      dah_total = dah_total - dah_ring[ring_ptr] + rh;
      dit_ring[ring_ptr] = rd;
      dah_ring[ring_ptr] = rh;
      ring_ptr = (ring_ptr == ipk_pkg::FILTER_LEN - 1) ? '0 : ring_ptr + 1'b1;
      dp = dit_total < press_limit;
      hp = dah_total < press_limit;
      r.dit_pressed = dp;
      r.dah_pressed = hp;
      if (keyer_on) begin
        // silent: drop an overflowed code, then maybe start an element
        if (quiet_left == 0) begin
          if (elem_count >= ipk_pkg::MAX_ELEMENTS) begin
            elem_count = '0;
            elem_bits = '0;
          end
          if (dp && hp) begin
            go = 1'b1;
            kind = dah_next;
          end else if (dp) begin
            go = 1'b1;
          end else if (hp) begin
            go = 1'b1;
            kind = 1'b1;
          end
          if (go) begin
            tone_left = kind ? dah_len : dit_len;
            if (elem_count < ipk_pkg::MAX_ELEMENTS) begin
              if (kind) elem_bits[elem_count[ipk_pkg::BIT_IDX_W-1:0]] = 1'b1;
              elem_count = elem_count + 1'b1;
            end
            letter_left = letter_gap;
            quiet_left = elem_gap + tone_left;
            dah_next = ~kind;
            r.element_start = 1'b1;
            r.element_is_dah = kind;
          end
        end
        // timers: tone/silence, then letter gap, letter end, word gap, word space
        if (quiet_left > 0) begin
          quiet_left = quiet_left - 1'b1;
          if (tone_left > 0) begin
            tone_level = 1'b1;
            tone_left = tone_left - 1'b1;
          end else begin
            tone_level = 1'b0;
          end
        end else if (letter_left > 0) begin
          letter_left = letter_left - 1'b1;
        end else if (elem_count != 0) begin
          r.letter_done = 1'b1;
          r.letter_length = elem_count;
          r.letter_pattern = elem_bits;
          elem_count = '0;
          elem_bits = '0;
          word_left = word_gap;
          space_done = 1'b0;
        end else if (word_left > 0) begin
          word_left = word_left - 1'b1;
        end else if (!space_done) begin
          r.word_space = 1'b1;
          space_done = 1'b1;
        end
      end
      r.tone_on = tone_level;
      due_reports.push_back(r);
    endfunction

    function void flag(string what);
      fault_count++;
      if (fault_count <= 10) $display("MISMATCH %s", what);
    endfunction

    function string show(report_t r);
      return $sformatf({"dit=%b dah=%b tone=%b start=%b is_dah=%b done=%b",
                        " len=%0d pat=%02h ws=%b"},
                       r.dit_pressed, r.dah_pressed, r.tone_on, r.element_start,
                       r.element_is_dah, r.letter_done, r.letter_length,
                       r.letter_pattern, r.word_space);
    endfunction

    function void check_report(report_t got);
      report_t want;
      string diff;
      if (due_reports.size() == 0) begin
        flag({"report beat with no tick pending: ", show(got)});
        return;
      end
      want = due_reports.pop_front();
      diff = "";
      if (got.dit_pressed !== want.dit_pressed) diff = {diff, " dit_pressed"};
      if (got.dah_pressed !== want.dah_pressed) diff = {diff, " dah_pressed"};
      if (got.tone_on !== want.tone_on) diff = {diff, " tone_on"};
      if (got.element_start !== want.element_start) diff = {diff, " element_start"};
      if (got.element_is_dah !== want.element_is_dah) diff = {diff, " element_is_dah"};
      if (got.letter_done !== want.letter_done) diff = {diff, " letter_done"};
      if (got.letter_length !== want.letter_length) diff = {diff, " letter_length"};
      if (got.letter_pattern !== want.letter_pattern) diff = {diff, " letter_pattern"};
      if (got.word_space !== want.word_space) diff = {diff, " word_space"};
      if (diff != "")
        flag($sformatf("on%s: expected %s, got %s", diff, show(want), show(got)));
    endfunction
  endclass

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [ipk_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ipk_pkg::CFG_DATA_W-1:0] cfg_data;

  ipk_paddle_if paddle_ch ();
  ipk_report_if report_ch ();

  iambic_paddle_keyer dut (
    .clk       (clk),
    .rst       (rst),
    .paddle    (paddle_ch),
    .report    (report_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  keyer_score sb;
  int         burst_left;
  int         hold_left;
  bit [1:0]   hold_level;  // {dah, dit}, active low
  bit         hold_noise;
  bit         hold_request;

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // Hard stop
  initial begin
    #(2 * HALF_PERIOD * TIMEOUT_CYCLES);
    $display("status: fail");
    $finish;
  end

  // Result monitor
  always @(posedge clk) begin
    report_t got;
    if (rst === 1'b0 && report_ch.valid === 1'b1 && report_ch.ready === 1'b1) begin
      got.dit_pressed = report_ch.dit_pressed;
      got.dah_pressed = report_ch.dah_pressed;
      got.tone_on = report_ch.tone_on;
      got.element_start = report_ch.element_start;
      got.element_is_dah = report_ch.element_is_dah;
      got.letter_done = report_ch.letter_done;
      got.letter_length = report_ch.letter_length;
      got.letter_pattern = report_ch.letter_pattern;
      got.word_space = report_ch.word_space;
      sb.check_report(got);
    end
  end

  // Result sink: stall patterns, plus one long hold-off on request
  initial begin : report_sink
    rx_mode_t mode;
    int       mode_left;
    int       tick;
    mode = RX_OPEN;
    mode_left = 0;
    tick = 0;
    report_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        report_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        tick++;
        case (mode)
          RX_OPEN:     report_ch.ready <= 1'b1;
          RX_MOSTLY:   report_ch.ready <= ($urandom_range(0, 3) != 0);
          RX_PERIODIC: report_ch.ready <= (tick % 4 != 3);
          default:     report_ch.ready <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  // One register write; the caller lowers cfg_we after its last write
  task automatic set_reg(logic [ipk_pkg::CFG_IDX_W-1:0] idx,
                         logic [ipk_pkg::CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  task automatic load_timing(bit en, logic [ipk_pkg::CFG_DATA_W-1:0] thr_word,
                             logic [ipk_pkg::TICK_W-1:0] dit,
                             logic [ipk_pkg::TICK_W-1:0] dah,
                             logic [ipk_pkg::TICK_W-1:0] egap,
                             logic [ipk_pkg::TICK_W-1:0] lgap,
                             logic [ipk_pkg::TICK_W-1:0] wgap);
    set_reg(ipk_pkg::REG_KEYER_ENABLE, {15'd0, en});
    set_reg(ipk_pkg::REG_PRESS_THRESHOLD, thr_word);
    set_reg(ipk_pkg::REG_DIT_TICKS, dit);
    set_reg(ipk_pkg::REG_DAH_TICKS, dah);
    set_reg(ipk_pkg::REG_ELEMENT_GAP_TICKS, egap);
    set_reg(ipk_pkg::REG_LETTER_GAP_TICKS, lgap);
    set_reg(ipk_pkg::REG_WORD_GAP_TICKS, wgap);
    cfg_we <= 1'b0;
  endtask

  // Offer one tick in bursts with random gaps; wait for the beat
  task automatic offer_tick(bit rd, bit rh);
    if (burst_left == 0) begin
      paddle_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 40);
    end
    burst_left--;
    paddle_ch.valid <= 1'b1;
    paddle_ch.raw_dit <= rd;
    paddle_ch.raw_dah <= rh;
    do @(posedge clk); while (paddle_ch.ready !== 1'b1);
    sb.note_tick(rd, rh);
  endtask

  task automatic hold_paddles(bit [1:0] level, int count);
    repeat (count) offer_tick(level[0], level[1]);
  endtask

  // Mostly steady paddle holds of random length, some bouncing noise
  task automatic drive_paddles(int count, int hold_max);
    bit [1:0] bits;
    repeat (count) begin
      if (hold_left == 0) begin
        hold_noise = ($urandom_range(0, 9) < 2);
        hold_level = 2'($urandom_range(0, 3));
        hold_left = hold_noise ? $urandom_range(1, 12) : $urandom_range(1, hold_max);
      end
      hold_left--;
      bits = hold_noise ? 2'($urandom) : hold_level;
      offer_tick(bits[0], bits[1]);
    end
  endtask

  // Stop offering and wait until every report is back or the drain limit runs out
  task automatic finish_phase();
    int guard;
    guard = 0;
    paddle_ch.valid <= 1'b0;
    burst_left = 0;
    do begin
      @(posedge clk);
      guard++;
    end while (sb.due_reports.size() != 0 && guard < DRAIN_LIMIT);
  endtask

  initial begin : stimulus
    int       p;
    bit [4:0] thr;
    sb = new();
    burst_left = 0;
    hold_left = 0;
    hold_level = 2'b11;
    hold_noise = 1'b0;
    hold_request = 1'b0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= ipk_pkg::REG_KEYER_ENABLE;
    cfg_data <= '0;
    paddle_ch.valid <= 1'b0;
    paddle_ch.raw_dit <= 1'b1;
    paddle_ch.raw_dah <= 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Reset defaults: empty ring reads as pressed, then the start word space
    hold_paddles(2'b11, 110);
    finish_phase();

    // Fast timing: dit, dah, squeeze past code overflow; masked and unmapped writes
    set_reg(REG_UNMAPPED, 16'hFFFF);
    load_timing(1'b1, 16'hFFE8, 16'd1, 16'd3, 16'd1, 16'd2, 16'd3);
    hold_paddles(2'b10, 20);
    hold_paddles(2'b11, 24);
    hold_paddles(2'b01, 20);
    hold_paddles(2'b11, 24);
    hold_paddles(2'b00, 48);
    hold_paddles(2'b11, 24);
    finish_phase();

    // Zero tone lengths and zero gaps, widest threshold
    load_timing(1'b1, 16'd16, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    hold_paddles(2'b00, 20);
    hold_paddles(2'b10, 6);
    hold_paddles(2'b11, 20);
    finish_phase();

    // No element gap: tone level lingers through idle ticks
    load_timing(1'b1, 16'd8, 16'd2, 16'd2, 16'd0, 16'd3, 16'd2);
    hold_paddles(2'b00, 16);
    hold_paddles(2'b11, 24);
    finish_phase();

    // Keyer off, then on with a threshold that never presses
    load_timing(1'b0, 16'd8, 16'd2, 16'd4, 16'd1, 16'd3, 16'd4);
    hold_paddles(2'b00, 12);
    hold_paddles(2'b11, 12);
    finish_phase();
    load_timing(1'b1, 16'd0, 16'd2, 16'd4, 16'd1, 16'd3, 16'd4);
    hold_paddles(2'b00, 12);
    finish_phase();

    // Random phases with short timings
    for (p = 0; p < 12; p++) begin
      case ($urandom_range(0, 5))
        0:       thr = 5'd0;
        1:       thr = 5'd16;
        default: thr = 5'($urandom_range(3, 13));
      endcase
      load_timing($urandom_range(0, 7) != 0,
                  {($urandom_range(0, 1) != 0) ? 11'($urandom) : 11'd0, thr},
                  16'($urandom_range(0, 4)), 16'($urandom_range(0, 8)),
                  16'($urandom_range(0, 4)), 16'($urandom_range(0, 12)),
                  16'($urandom_range(0, 20)));
      if (p == 4) hold_request = 1'b1;
      drive_paddles(40, 40);
      finish_phase();
    end

    // Largest timer values with a dit held down
    load_timing(1'b1, 16'd16, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    hold_paddles(2'b10, 30);
    finish_phase();

    repeat (4) @(posedge clk);
    if (sb.due_reports.size() != 0)
      sb.flag($sformatf("%0d reports never arrived", sb.due_reports.size()));
    if (sb.fault_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ipk_pkg.sv
rtl/ipk_paddle_if.sv
rtl/ipk_report_if.sv
rtl/ipk_debounce.sv
rtl/iambic_paddle_keyer.sv
test/tb.sv
